### rtl/deq_pkg.sv
// Shared types and codes of the double-ended queue.
`default_nettype none

package deq_pkg;

	typedef enum logic [2:0] {
		REQ_PUSH_BACK  = 3'd0,
		REQ_POP_BACK   = 3'd1,
		REQ_PUSH_FRONT = 3'd2,
		REQ_POP_FRONT  = 3'd3,
		REQ_GET        = 3'd4,
		REQ_LAST       = 3'd5,
		REQ_REPLACE    = 3'd6,
		REQ_REMOVE     = 3'd7
	} req_t;

	typedef enum logic [1:0] {
		STS_OK    = 2'd0,
		STS_EMPTY = 2'd1,
		STS_FULL  = 2'd2,
		STS_RANGE = 2'd3
	} sts_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RDATA,
		ST_SHIFT_RD,
		ST_SHIFT_WR
	} deq_state_t;

	localparam int unsigned REQ_W = 3;
	localparam int unsigned STS_W = 2;

endpackage

`default_nettype wire

### rtl/double_ended_queue.sv
// Double-ended queue: a circular entry store with pointer and count control.
//
// One request is taken at a time and answered by exactly one result item carrying
// read data, status and the entry count after the request. The entries live in a
// single synchronous memory with a registered read port, so a pop, get or last
// issues the read in the execute state and captures the read data in the read-data
// state, while a push, replace or failed request loads its result from the execute
// state. Remove at position p moves each later entry one slot towards the front,
// each by a read state and then a write-back state. The result register decouples
// the output side: a new request is accepted while the previous result waits, and
// the block stalls only when it must load a result that has not yet been taken.
`default_nettype none

module double_ended_queue
	import deq_pkg::*;
#(
	parameter int unsigned DEPTH      = 16,
	parameter int unsigned DATA_WIDTH = 32,
	localparam int unsigned AW        = $clog2(DEPTH),
	localparam int unsigned CW        = $clog2(DEPTH + 1),
	localparam int unsigned S_W       = REQ_W + AW + DATA_WIDTH,
	localparam int unsigned S_TDW     = ((S_W + 7) / 8) * 8,
	localparam int unsigned M_W       = DATA_WIDTH + STS_W + CW,
	localparam int unsigned M_TDW     = ((M_W + 7) / 8) * 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [S_TDW-1:0] s_tdata,  // req_type, position, wr_data, zero pad
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [M_TDW-1:0]      m_tdata   // rd_data, status, count, zero pad
);

	localparam int unsigned CNT_W = AW + 1;
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

	deq_state_t state_q, state_d;

	logic [AW-1:0]         front_q;
	logic [CNT_W-1:0]      count_q;
	req_t                  req_q;
	logic [AW-1:0]         pos_q;
	logic [DATA_WIDTH-1:0] wdata_q;
	logic [AW-1:0]         idx_q;

	logic                  m_tvalid_q;
	logic [DATA_WIDTH-1:0] rd_q;
	sts_t                  sts_q;
	logic [CNT_W-1:0]      cnt_out_q;

	logic [DATA_WIDTH-1:0] mem [DEPTH];
	logic [DATA_WIDTH-1:0] rdata_s1;

	// control
	logic                  out_free;
	logic                  out_load;
	logic                  out_from_mem;
	sts_t                  out_sts;
	logic                  mem_we;
	logic [AW-1:0]         mem_waddr;
	logic [DATA_WIDTH-1:0] mem_wdata;
	logic                  mem_re;
	logic [AW-1:0]         mem_raddr;
	logic                  cnt_inc;
	logic                  cnt_dec;
	logic                  front_set;
	logic [AW-1:0]         front_nxt;
	logic                  idx_load;
	logic                  idx_inc;
	logic                  go_read;
	logic                  go_shift;

	logic                  empty;
	logic                  full;
	logic                  in_range;
	logic                  more_to_shift;
	logic [CNT_W-1:0]      cnt_m1;
	logic [CNT_W-1:0]      idx_p1;
	logic [AW-1:0]         slot_back;
	logic [AW-1:0]         slot_last;
	logic [AW-1:0]         slot_pos;
	logic [AW-1:0]         slot_next;
	logic [AW-1:0]         slot_idx;
	logic [AW-1:0]         slot_idx_p1;
	logic [AW-1:0]         front_dec;

	// Wrap front + offset into the store; the sum stays below twice the depth.
	function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
			input logic [CNT_W-1:0] off);
		logic [CNT_W:0] sum;
		sum = {2'b00, base} + {1'b0, off};
		if (sum >= (CNT_W + 1)'(DEPTH)) begin
			sum = sum - (CNT_W + 1)'(DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	assign out_free      = !m_tvalid_q || m_tready;
	assign empty         = (count_q == '0);
	assign full          = (count_q == DEPTH_C);
	assign in_range      = ({1'b0, pos_q} < count_q);
	assign cnt_m1        = count_q - CNT_W'(1);
	assign idx_p1        = {1'b0, idx_q} + CNT_W'(1);
	assign more_to_shift = (idx_p1 < count_q);
	assign slot_back     = slot_of(front_q, count_q);
	assign slot_last     = slot_of(front_q, cnt_m1);
	assign slot_pos      = slot_of(front_q, {1'b0, pos_q});
	assign slot_next     = slot_of(front_q, CNT_W'(1));
	assign slot_idx      = slot_of(front_q, {1'b0, idx_q});
	assign slot_idx_p1   = slot_of(front_q, idx_p1);
	assign front_dec     = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (out_free) begin
					if (go_read) state_d = ST_RDATA;
					else if (go_shift) state_d = ST_SHIFT_RD;
					else state_d = ST_IDLE;
				end
			end
			ST_RDATA: state_d = ST_IDLE;
			ST_SHIFT_RD: begin
				if (more_to_shift) state_d = ST_SHIFT_WR;
				else if (out_free) state_d = ST_IDLE;
			end
			ST_SHIFT_WR: state_d = ST_SHIFT_RD;
			default: state_d = ST_IDLE;
		endcase
	end

	// Control outputs
	always_comb begin
		s_tready     = 1'b0;
		out_load     = 1'b0;
		out_from_mem = 1'b0;
		out_sts      = STS_OK;
		mem_we       = 1'b0;
		mem_waddr    = slot_pos;
		mem_wdata    = wdata_q;
		mem_re       = 1'b0;
		mem_raddr    = slot_pos;
		cnt_inc      = 1'b0;
		cnt_dec      = 1'b0;
		front_set    = 1'b0;
		front_nxt    = front_q;
		idx_load     = 1'b0;
		idx_inc      = 1'b0;
		go_read      = 1'b0;
		go_shift     = 1'b0;
		case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_EXEC: begin
				if (out_free) begin
					case (req_q)
						REQ_PUSH_BACK: begin
							out_load = 1'b1;
							if (full) begin
								out_sts = STS_FULL;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = slot_back;
								cnt_inc   = 1'b1;
							end
						end
						REQ_POP_BACK: begin
							if (empty) begin
								out_load = 1'b1;
								out_sts  = STS_EMPTY;
							end else begin
								mem_re    = 1'b1;
								mem_raddr = slot_last;
								cnt_dec   = 1'b1;
								go_read   = 1'b1;
							end
						end
						REQ_PUSH_FRONT: begin
							out_load = 1'b1;
							if (full) begin
								out_sts = STS_FULL;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = front_dec;
								front_set = 1'b1;
								front_nxt = front_dec;
								cnt_inc   = 1'b1;
							end
						end
						REQ_POP_FRONT: begin
							if (empty) begin
								out_load = 1'b1;
								out_sts  = STS_EMPTY;
							end else begin
								mem_re    = 1'b1;
								mem_raddr = front_q;
								front_set = 1'b1;
								front_nxt = slot_next;
								cnt_dec   = 1'b1;
								go_read   = 1'b1;
							end
						end
						REQ_GET: begin
							if (!in_range) begin
								out_load = 1'b1;
								out_sts  = STS_RANGE;
							end else begin
								mem_re    = 1'b1;
								mem_raddr = slot_pos;
								go_read   = 1'b1;
							end
						end
						REQ_LAST: begin
							if (empty) begin
								out_load = 1'b1;
								out_sts  = STS_EMPTY;
							end else begin
								mem_re    = 1'b1;
								mem_raddr = slot_last;
								go_read   = 1'b1;
							end
						end
						REQ_REPLACE: begin
							out_load = 1'b1;
							if (!in_range) begin
								out_sts = STS_RANGE;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = slot_pos;
							end
						end
						REQ_REMOVE: begin
							if (!in_range) begin
								out_load = 1'b1;
								out_sts  = STS_RANGE;
							end else begin
								idx_load = 1'b1;
								go_shift = 1'b1;
							end
						end
						default: begin
							out_load = 1'b1;
						end
					endcase
				end
			end
			ST_RDATA: begin
				out_load     = 1'b1;
				out_from_mem = 1'b1;
			end
			ST_SHIFT_RD: begin
				if (more_to_shift) begin
					mem_re    = 1'b1;
					mem_raddr = slot_idx_p1;
				end else if (out_free) begin
					cnt_dec  = 1'b1;
					out_load = 1'b1;
				end
			end
			ST_SHIFT_WR: begin
				// move the entry behind one slot towards the front
				mem_we    = 1'b1;
				mem_waddr = slot_idx;
				mem_wdata = rdata_s1;
				idx_inc   = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			front_q    <= '0;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (front_set) front_q <= front_nxt;
			if (cnt_inc) count_q <= count_q + CNT_W'(1);
			else if (cnt_dec) count_q <= cnt_m1;
			if (out_load) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	// Request and result payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_q   <= req_t'(s_tdata[REQ_W-1:0]);
			pos_q   <= s_tdata[REQ_W +: AW];
			wdata_q <= s_tdata[REQ_W + AW +: DATA_WIDTH];
		end
		if (idx_load) idx_q <= pos_q;
		else if (idx_inc) idx_q <= idx_p1[AW-1:0];
		if (out_load) begin
			rd_q <= out_from_mem ? rdata_s1 : '0;
			sts_q <= out_sts;
			// count after the request, including a decrement taken this cycle
			if (cnt_inc) cnt_out_q <= count_q + CNT_W'(1);
			else if (cnt_dec) cnt_out_q <= cnt_m1;
			else cnt_out_q <= count_q;
		end
	end

	// Entry store
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
	end

	always_ff @(posedge clk) begin
		if (mem_re) rdata_s1 <= mem[mem_raddr];
	end

	assign m_tvalid = m_tvalid_q;

	always_comb begin
		m_tdata = '0;
		m_tdata[DATA_WIDTH-1:0]           = rd_q;
		m_tdata[DATA_WIDTH +: STS_W]      = sts_q;
		m_tdata[DATA_WIDTH + STS_W +: CW] = cnt_out_q[CW-1:0];
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= DEPTH_C)
		else $error("entry count above capacity");

	assert property (@(posedge clk) disable iff (!arst_n)
			(s_tvalid && s_tready) |=> !s_tready)
		else $error("second item accepted while one is in progress");

	assert property (@(posedge clk) disable iff (!arst_n)
			(m_tvalid_q && sts_q == STS_FULL) |-> (cnt_out_q == DEPTH_C))
		else $error("full reported below capacity");

	assert property (@(posedge clk) disable iff (!arst_n)
			(m_tvalid_q && sts_q == STS_EMPTY) |-> (cnt_out_q == '0 && rd_q == '0))
		else $error("empty reported with entries held or data");

endmodule

`default_nettype wire

### tb/sv/tb.sv
// Self-checking testbench of the double-ended queue: directed corner requests, then random traffic.
`default_nettype none

module tb;
	import deq_pkg::*;

	typedef struct {
		logic [31:0] rd;
		sts_t        status;
		logic [4:0]  count;
	} answer_t;

	// Predicts each answer of the queue and checks the result items against it.
	class deque_scoreboard;
		logic [31:0] slots [16];
		logic [3:0]  head;
		logic [4:0]  held;
		answer_t     answers [$];
		int unsigned errors;
		int unsigned taken;
		int unsigned results;
		int unsigned sts_seen [4];

		function new();
			head = '0;
			held = '0;
			errors = 0;
			taken = 0;
			results = 0;
			foreach (sts_seen[k]) sts_seen[k] = 0;
		endfunction

		function logic [3:0] slot_at(logic [4:0] offset);
			return head + offset[3:0];
		endfunction

		function void note_request(req_t op, logic [3:0] pos, logic [31:0] din);
			answer_t a;
			a.rd = '0;
			a.status = STS_OK;
			case (op)
				REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
					if (held == 5'd16) begin
						a.status = STS_FULL;
					end else if (op == REQ_PUSH_BACK) begin
						slots[slot_at(held)] = din;
						held++;
					end else begin
						head = head - 4'd1;
						slots[head] = din;
						held++;
					end
				end
				REQ_POP_BACK: begin
					if (held == 0) begin
						a.status = STS_EMPTY;
					end else begin
						held--;
						a.rd = slots[slot_at(held)];
					end
				end
				REQ_POP_FRONT: begin
					if (held == 0) begin
						a.status = STS_EMPTY;
					end else begin
						a.rd = slots[head];
						head = head + 4'd1;
						held--;
					end
				end
				REQ_LAST: begin
					if (held == 0) a.status = STS_EMPTY;
					else a.rd = slots[slot_at(held - 5'd1)];
				end
				REQ_GET: begin
					if ({1'b0, pos} >= held) a.status = STS_RANGE;
					else a.rd = slots[slot_at({1'b0, pos})];
				end
				REQ_REPLACE: begin
					if ({1'b0, pos} >= held) a.status = STS_RANGE;
					else slots[slot_at({1'b0, pos})] = din;
				end
				default: begin
					if ({1'b0, pos} >= held) begin
						a.status = STS_RANGE;
					end else begin
						// close the gap towards the front
						for (int i = pos; i + 1 < held; i++)
							slots[slot_at(5'(i))] = slots[slot_at(5'(i + 1))];
						held--;
					end
				end
			endcase
			a.count = held;
			sts_seen[a.status]++;
			taken++;
			answers.push_back(a);
		endfunction

		task report(string msg);
			$display("ERROR: %s", msg);
			errors++;
		endtask

		task check_result(logic [39:0] word);
			answer_t want;
			results++;
			if (answers.size() == 0) begin
				report($sformatf("result %0d arrived with nothing expected", results));
			end else begin
				want = answers.pop_front();
				if (word[31:0] !== want.rd)
					report($sformatf("result %0d rd_data %0h, expected %0h",
						results, word[31:0], want.rd));
				if (word[33:32] !== want.status)
					report($sformatf("result %0d status %0d, expected %0d",
						results, word[33:32], want.status));
				if (word[38:34] !== want.count)
					report($sformatf("result %0d count %0d, expected %0d",
						results, word[38:34], want.count));
			end
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;

	deque_scoreboard sb = new;
	bit gaps_on = 1'b1;
	int stall_left = 0;

	double_ended_queue DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Result side: take items, with occasional stall bursts.
	always @(posedge clk) begin
		if (m_tvalid && m_tready) sb.check_result(m_tdata);
		if (stall_left != 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (gaps_on && arst_n && $urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(0, 2);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic send_item(req_t op, logic [3:0] pos, logic [31:0] din);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, din, pos, op};
		do @(posedge clk); while (!s_tready);
		sb.note_request(op, pos, din);
	endtask

	// Hold the request side until every answer is back.
	task automatic drain_answers();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.answers.size() != 0);
	endtask

	function automatic logic [31:0] pick_data();
		case ($urandom_range(0, 7))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// mode 0 fills, mode 1 drains, mode 2 stays balanced
	function automatic req_t pick_request(int mode);
		int roll;
		int push_w;
		int pop_w;
		roll = $urandom_range(0, 99);
		push_w = (mode == 0) ? 55 : (mode == 1) ? 15 : 33;
		pop_w = (mode == 0) ? 15 : (mode == 1) ? 50 : 27;
		if (roll < push_w) return $urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
		if (roll < push_w + pop_w) return $urandom_range(0, 1) ? REQ_POP_BACK : REQ_POP_FRONT;
		case ($urandom_range(0, 3))
			0: return REQ_GET;
			1: return REQ_LAST;
			2: return REQ_REPLACE;
			default: return REQ_REMOVE;
		endcase
	endfunction

	initial begin
		int n_random;
		int mode;
		logic [3:0] pos;
		n_random = 1020;
		mode = 2;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue: every read and indexed request must fail
		send_item(REQ_POP_BACK, 4'd0, 32'h0);
		send_item(REQ_POP_FRONT, 4'd0, 32'h0);
		send_item(REQ_LAST, 4'd0, 32'h0);
		send_item(REQ_GET, 4'd0, 32'h0);
		send_item(REQ_REPLACE, 4'd0, 32'hFFFF_FFFF);
		send_item(REQ_REMOVE, 4'd15, 32'h0);
		// fill from both ends, wrapping the front pointer
		for (int i = 0; i < 16; i++)
			send_item((i % 2) ? REQ_PUSH_FRONT : REQ_PUSH_BACK, 4'(i),
				(i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF : $urandom);
		send_item(REQ_PUSH_BACK, 4'd0, 32'hA5A5_A5A5);
		send_item(REQ_PUSH_FRONT, 4'd0, 32'h5A5A_5A5A);
		send_item(REQ_GET, 4'd15, 32'h0);
		send_item(REQ_REPLACE, 4'd0, 32'hFFFF_FFFF);
		send_item(REQ_REMOVE, 4'd15, 32'h0);
		send_item(REQ_REMOVE, 4'd0, 32'h0);
		send_item(REQ_GET, 4'd14, 32'h0);
		send_item(REQ_LAST, 4'd0, 32'h0);
		drain_answers();

		for (int i = 0; i < n_random; i++) begin
			if (i % 40 == 0) mode = $urandom_range(0, 2);
			if (i > 0 && i % 250 == 0) drain_answers();
			if (i == n_random - 150) gaps_on = 1'b0;
			if (sb.held != 0 && $urandom_range(0, 3) != 0)
				pos = 4'($urandom_range(0, sb.held - 1));
			else
				pos = 4'($urandom_range(0, 15));
			send_item(pick_request(mode), pos, pick_data());
		end
		s_tvalid <= 1'b0;

		for (int w = 0; w < 5000 && sb.answers.size() != 0; w++) @(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.answers.size() != 0)
			sb.report($sformatf("%0d expected results never arrived", sb.answers.size()));

		$display("Summary: %0d requests accepted, %0d results checked", sb.taken, sb.results);
		$display("Answers: ok %0d, empty %0d, full %0d, out of range %0d",
			sb.sts_seen[STS_OK], sb.sts_seen[STS_EMPTY], sb.sts_seen[STS_FULL],
			sb.sts_seen[STS_RANGE]);
		if (sb.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("ERROR: run timed out");
		$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire
